### hdl/lpgu_pkg.sv
// Shared types and constants for the layout pair gradient update block.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`timescale 1ns / 1ps

package lpgu_pkg;

    localparam int MAX_VERTICES_DEF  = 16384;
    localparam int MAX_DIMENSION_DEF = 4;

    localparam int VERTEX_W    = 14;
    localparam int COORD_IDX_W = 2;
    localparam int VALUE_W     = 32;
    localparam int LR_W        = 17;
    localparam int DIM_W       = 3;
    localparam int GAMMA_W     = 24;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int DIST_W      = 31;
    localparam int GRAD_W      = 45;

    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA     = 2'd1;

    localparam logic [DIM_W-1:0]   DIM_RESET   = 3'd2;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 24'd65536;

    localparam logic [LR_W-1:0]   Q_ONE      = 17'd65536;
    localparam logic [31:0]       Q_ONE_32   = 32'd65536;
    localparam logic [31:0]       Q_TENTH_32 = 32'd6554;
    localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};

    // shared shift-add / shift-subtract unit
    localparam int ALU_A_W    = 57;
    localparam int ALU_B_W    = 33;
    localparam int ALU_P_W    = ALU_A_W + ALU_B_W;
    localparam int ALU_CNT_W  = 6;
    localparam int MUL_STEPS  = ALU_B_W;
    localparam int DIV_STEPS  = ALU_A_W;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic               start;
        t_alu_op            op;
        logic [ALU_A_W-1:0] a;
        logic [ALU_B_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [ALU_P_W-1:0] result;
    } t_alu_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_RD_DATA,
        S_P1_RD,
        S_P1_DIFF,
        S_P1_MUL,
        S_G1,
        S_G1W,
        S_G2W,
        S_P2_RD,
        S_P2_DIFF,
        S_P2_MUL,
        S_P2_WA,
        S_P2_WB,
        S_FIN
    } t_state;

endpackage

### hdl/layout_pair_gradient_update.sv
// Top level: command sequencer, configuration registers and result register.
// Depends on lpgu_pkg, lpgu_store and lpgu_alu.
// Pair updates use the bit-serial unit: a multiply per coordinate for the distance, one
// divide (attractive) or two (repulsive), then a multiply per coordinate for the step.
// One item at a time; a new item is taken once the result is registered.
// Reset clears the sequencer, the result valid flag and the configuration (dim 2,
// gamma 1.0); the coordinate memory is not cleared.
`timescale 1ns / 1ps

module layout_pair_gradient_update #(
    parameter int MAX_VERTICES  = lpgu_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DIMENSION = lpgu_pkg::MAX_DIMENSION_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [lpgu_pkg::CMD_W-1:0]       i_command,
    input  logic [lpgu_pkg::VERTEX_W-1:0]    i_vertex_a,
    input  logic [lpgu_pkg::VERTEX_W-1:0]    i_vertex_b,
    input  logic [lpgu_pkg::COORD_IDX_W-1:0] i_coordinate_index,
    input  logic signed [lpgu_pkg::VALUE_W-1:0] i_write_value,
    input  logic [lpgu_pkg::LR_W-1:0]        i_learning_rate,
    input  logic                             i_attract,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [lpgu_pkg::VALUE_W-1:0] o_read_value,
    output logic                             o_saturated,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lpgu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lpgu_pkg::GAMMA_W-1:0]     i_cfg_data
);

    localparam int DEPTH  = MAX_VERTICES * MAX_DIMENSION;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int K_W    = $clog2(MAX_DIMENSION + 1);

    function automatic logic [ADDR_W-1:0] slot(input logic [lpgu_pkg::VERTEX_W-1:0] v,
                                               input logic [3:0] c);
        return ADDR_W'(v) * ADDR_W'(MAX_DIMENSION) + ADDR_W'(c);
    endfunction

    // {overflow, value} of a 34-bit signed sum clipped to 32 bits
    function automatic logic [32:0] sat_value(input logic [33:0] s);
        logic ovf;
        ovf = (s[33:31] != 3'b000) && (s[33:31] != 3'b111);
        if (!ovf) begin
            return {1'b0, s[31:0]};
        end
        return {1'b1, s[33] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    endfunction

    lpgu_pkg::t_state r_state, n_state;

    logic [lpgu_pkg::DIM_W-1:0]       r_dim;
    logic [lpgu_pkg::GAMMA_W-1:0]     r_gamma;

    logic [lpgu_pkg::VERTEX_W-1:0]    r_va, n_va;
    logic [lpgu_pkg::VERTEX_W-1:0]    r_vb, n_vb;
    logic [lpgu_pkg::COORD_IDX_W-1:0] r_ci, n_ci;
    logic [lpgu_pkg::LR_W-1:0]        r_lr, n_lr;
    logic                             r_attract, n_attract;
    logic [K_W-1:0]                   r_dim_use, n_dim_use;
    logic [K_W-1:0]                   r_k, n_k;
    logic [lpgu_pkg::DIST_W-1:0]      r_dist, n_dist;
    logic [lpgu_pkg::GRAD_W-1:0]      r_grad, n_grad;
    logic                             r_neg, n_neg;
    logic [lpgu_pkg::LR_W-1:0]        r_u, n_u;
    logic                             r_sat, n_sat;
    logic [lpgu_pkg::VALUE_W-1:0]     r_res_value, n_res_value;

    logic                             r_out_valid;
    logic [lpgu_pkg::VALUE_W-1:0]     r_out_value;
    logic                             r_out_sat;

    logic                             in_fire;
    logic                             out_load;
    logic                             va_ok, vb_ok, ci_ok;
    logic                             k_last;

    logic                             mem_we, mem_re;
    logic [ADDR_W-1:0]                mem_waddr, mem_raddr_a, mem_raddr_b;
    logic [lpgu_pkg::VALUE_W-1:0]     mem_wdata, rd_a, rd_b;

    lpgu_pkg::t_alu_req               alu_req;
    lpgu_pkg::t_alu_rsp               alu_rsp;

    logic [32:0]                      diff;
    logic [32:0]                      mag;
    logic [49:0]                      sq;
    logic [50:0]                      dist_sum;
    logic [57:0]                      p_full;
    logic [lpgu_pkg::LR_W-1:0]        p_clip;
    logic [33:0]                      lr_prod;
    logic [33:0]                      step;
    logic [32:0]                      wa_res, wb_res;

    lpgu_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re      (mem_re),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    lpgu_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    assign o_in_ready  = (r_state == lpgu_pkg::S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_load    = (r_state == lpgu_pkg::S_FIN) && (!r_out_valid || i_out_ready);
    assign o_cfg_ready = 1'b1;

    assign va_ok  = int'(i_vertex_a) < MAX_VERTICES;
    assign vb_ok  = int'(i_vertex_b) < MAX_VERTICES;
    assign ci_ok  = int'(i_coordinate_index) < MAX_DIMENSION;
    assign k_last = (r_k + K_W'(1)) == r_dim_use;

    // shared datapath pieces
    always_comb begin
        diff     = {rd_a[31], rd_a} - {rd_b[31], rd_b};
        mag      = diff[32] ? (33'd0 - diff) : diff;
        sq       = alu_rsp.result[65:16];
        dist_sum = {20'd0, r_dist} + {1'b0, sq};
        p_full   = alu_rsp.result[89:32];
        p_clip   = (p_full > 58'(lpgu_pkg::Q_ONE)) ? lpgu_pkg::Q_ONE : p_full[16:0];
        lr_prod  = 34'(r_lr) * 34'(p_clip);
        step     = r_neg ? (34'd0 - {17'd0, r_u}) : {17'd0, r_u};
        wa_res   = sat_value({{2{rd_a[31]}}, rd_a} + step);
        wb_res   = sat_value({{2{rd_b[31]}}, rd_b} - step);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpgu_pkg::S_IDLE: begin
                if (in_fire) begin
                    case (i_command)
                        lpgu_pkg::CMD_READ:
                            n_state = (va_ok && ci_ok) ? lpgu_pkg::S_RD : lpgu_pkg::S_FIN;
                        lpgu_pkg::CMD_UPDATE:
                            n_state = (va_ok && vb_ok) ? lpgu_pkg::S_P1_RD : lpgu_pkg::S_FIN;
                        default:
                            n_state = lpgu_pkg::S_FIN;
                    endcase
                end
            end
            lpgu_pkg::S_RD:      n_state = lpgu_pkg::S_RD_DATA;
            lpgu_pkg::S_RD_DATA: n_state = lpgu_pkg::S_FIN;
            lpgu_pkg::S_P1_RD:   n_state = lpgu_pkg::S_P1_DIFF;
            lpgu_pkg::S_P1_DIFF: n_state = lpgu_pkg::S_P1_MUL;
            lpgu_pkg::S_P1_MUL: begin
                if (alu_rsp.done) begin
                    n_state = k_last ? lpgu_pkg::S_G1 : lpgu_pkg::S_P1_RD;
                end
            end
            lpgu_pkg::S_G1:      n_state = lpgu_pkg::S_G1W;
            lpgu_pkg::S_G1W: begin
                if (alu_rsp.done) begin
                    n_state = r_attract ? lpgu_pkg::S_P2_RD : lpgu_pkg::S_G2W;
                end
            end
            lpgu_pkg::S_G2W: begin
                if (alu_rsp.done) begin
                    n_state = lpgu_pkg::S_P2_RD;
                end
            end
            lpgu_pkg::S_P2_RD:   n_state = lpgu_pkg::S_P2_DIFF;
            lpgu_pkg::S_P2_DIFF: n_state = lpgu_pkg::S_P2_MUL;
            lpgu_pkg::S_P2_MUL: begin
                if (alu_rsp.done) begin
                    n_state = lpgu_pkg::S_P2_WA;
                end
            end
            lpgu_pkg::S_P2_WA:   n_state = lpgu_pkg::S_P2_WB;
            lpgu_pkg::S_P2_WB:   n_state = k_last ? lpgu_pkg::S_FIN : lpgu_pkg::S_P2_RD;
            lpgu_pkg::S_FIN: begin
                if (out_load) begin
                    n_state = lpgu_pkg::S_IDLE;
                end
            end
            default:             n_state = lpgu_pkg::S_IDLE;
        endcase
    end

    // datapath and memory / unit controls
    always_comb begin
        n_va        = r_va;
        n_vb        = r_vb;
        n_ci        = r_ci;
        n_lr        = r_lr;
        n_attract   = r_attract;
        n_dim_use   = r_dim_use;
        n_k         = r_k;
        n_dist      = r_dist;
        n_grad      = r_grad;
        n_neg       = r_neg;
        n_u         = r_u;
        n_sat       = r_sat;
        n_res_value = r_res_value;

        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = slot(r_va, 4'(r_k));
        mem_wdata   = wa_res[31:0];
        mem_raddr_a = slot(r_va, 4'(r_k));
        mem_raddr_b = slot(r_vb, 4'(r_k));

        alu_req.start = 1'b0;
        alu_req.op    = lpgu_pkg::ALU_MUL;
        alu_req.a     = lpgu_pkg::ALU_A_W'(mag);
        alu_req.b     = mag;

        unique case (r_state)
            lpgu_pkg::S_IDLE: begin
                mem_waddr = slot(i_vertex_a, 4'(i_coordinate_index));
                mem_wdata = i_write_value;
                if (in_fire) begin
                    n_va        = i_vertex_a;
                    n_vb        = i_vertex_b;
                    n_ci        = i_coordinate_index;
                    n_lr        = (i_learning_rate > lpgu_pkg::Q_ONE) ? lpgu_pkg::Q_ONE
                                                                      : i_learning_rate;
                    n_attract   = i_attract;
                    n_k         = '0;
                    n_dist      = '0;
                    n_sat       = 1'b0;
                    n_res_value = '0;
                    if (r_dim == '0) begin
                        n_dim_use = K_W'(1);
                    end else if (int'(r_dim) > MAX_DIMENSION) begin
                        n_dim_use = K_W'(MAX_DIMENSION);
                    end else begin
                        n_dim_use = K_W'(r_dim);
                    end
                    mem_we = (i_command == lpgu_pkg::CMD_WRITE) && va_ok && ci_ok;
                end
            end
            lpgu_pkg::S_RD: begin
                mem_re      = 1'b1;
                mem_raddr_a = slot(r_va, 4'(r_ci));
            end
            lpgu_pkg::S_RD_DATA: begin
                n_res_value = rd_a;
            end
            lpgu_pkg::S_P1_RD: begin
                mem_re = 1'b1;
            end
            lpgu_pkg::S_P1_DIFF: begin
                alu_req.start = 1'b1;
            end
            lpgu_pkg::S_P1_MUL: begin
                if (alu_rsp.done) begin
                    if (dist_sum > {20'd0, lpgu_pkg::DIST_MAX}) begin
                        n_dist = lpgu_pkg::DIST_MAX;
                        n_sat  = 1'b1;
                    end else begin
                        n_dist = dist_sum[lpgu_pkg::DIST_W-1:0];
                    end
                    n_k = k_last ? '0 : r_k + K_W'(1);
                end
            end
            lpgu_pkg::S_G1: begin
                alu_req.start = 1'b1;
                alu_req.op    = lpgu_pkg::ALU_DIV;
                alu_req.a     = r_attract ? (lpgu_pkg::ALU_A_W'(1) << 49) : {r_gamma, 33'd0};
                alu_req.b     = {1'b0, lpgu_pkg::Q_ONE_32 + {1'b0, r_dist}};
            end
            lpgu_pkg::S_G1W: begin
                if (alu_rsp.done) begin
                    n_grad = alu_rsp.result[lpgu_pkg::GRAD_W-1:0];
                    // repulsive pair: second divide by (0.1 + d)
                    alu_req.start = !r_attract;
                    alu_req.op    = lpgu_pkg::ALU_DIV;
                    alu_req.a     = {alu_rsp.result[40:0], 16'd0};
                    alu_req.b     = {1'b0, lpgu_pkg::Q_TENTH_32 + {1'b0, r_dist}};
                end
            end
            lpgu_pkg::S_G2W: begin
                if (alu_rsp.done) begin
                    n_grad = alu_rsp.result[lpgu_pkg::GRAD_W-1:0];
                end
            end
            lpgu_pkg::S_P2_RD: begin
                mem_re = 1'b1;
            end
            lpgu_pkg::S_P2_DIFF: begin
                alu_req.start = 1'b1;
                alu_req.a     = lpgu_pkg::ALU_A_W'(r_grad);
                n_neg         = diff[32] ^ r_attract;
            end
            lpgu_pkg::S_P2_MUL: begin
                if (alu_rsp.done) begin
                    n_u = lr_prod[32:16];
                end
            end
            lpgu_pkg::S_P2_WA: begin
                mem_we = 1'b1;
                n_sat  = r_sat | wa_res[32];
            end
            lpgu_pkg::S_P2_WB: begin
                mem_we    = 1'b1;
                mem_waddr = slot(r_vb, 4'(r_k));
                mem_wdata = wb_res[31:0];
                n_sat     = r_sat | wb_res[32];
                n_k       = r_k + K_W'(1);
            end
            lpgu_pkg::S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpgu_pkg::S_IDLE;
            r_dim       <= lpgu_pkg::DIM_RESET;
            r_gamma     <= lpgu_pkg::GAMMA_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    lpgu_pkg::CFG_DIMENSION: r_dim   <= i_cfg_data[lpgu_pkg::DIM_W-1:0];
                    lpgu_pkg::CFG_GAMMA:     r_gamma <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_va        <= n_va;
        r_vb        <= n_vb;
        r_ci        <= n_ci;
        r_lr        <= n_lr;
        r_attract   <= n_attract;
        r_dim_use   <= n_dim_use;
        r_k         <= n_k;
        r_dist      <= n_dist;
        r_grad      <= n_grad;
        r_neg       <= n_neg;
        r_u         <= n_u;
        r_sat       <= n_sat;
        r_res_value <= n_res_value;
        if (out_load) begin
            r_out_value <= r_res_value;
            r_out_sat   <= r_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_saturated  = r_out_sat;

    a_idle_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpgu_pkg::S_IDLE) |-> !alu_rsp.busy)
        else $error("shared unit busy while sequencer idle");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == lpgu_pkg::S_P1_MUL || r_state == lpgu_pkg::S_G1W ||
                          r_state == lpgu_pkg::S_G2W || r_state == lpgu_pkg::S_P2_MUL))
        else $error("shared unit finished outside a wait state");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == lpgu_pkg::S_IDLE || r_state == lpgu_pkg::S_P2_WA ||
                    r_state == lpgu_pkg::S_P2_WB))
        else $error("memory write from unexpected state");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpgu_pkg::S_P1_RD || r_state == lpgu_pkg::S_P2_RD) |-> (r_k < r_dim_use))
        else $error("coordinate counter past dimension");

endmodule

### hdl/lpgu_store.sv
// Coordinate memory: one write port, two registered read ports.
// Depends on lpgu_pkg for the word width.
`timescale 1ns / 1ps

module lpgu_store #(
    parameter int DEPTH  = lpgu_pkg::MAX_VERTICES_DEF * lpgu_pkg::MAX_DIMENSION_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ADDR_W-1:0]            i_waddr,
    input  logic [lpgu_pkg::VALUE_W-1:0] i_wdata,
    input  logic                         i_re,
    input  logic [ADDR_W-1:0]            i_raddr_a,
    input  logic [ADDR_W-1:0]            i_raddr_b,
    output logic [lpgu_pkg::VALUE_W-1:0] o_rdata_a,
    output logic [lpgu_pkg::VALUE_W-1:0] o_rdata_b
);

    logic [lpgu_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [lpgu_pkg::VALUE_W-1:0] r_rd_a;
    logic [lpgu_pkg::VALUE_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        // hold read data between reads
        if (i_re) begin
            r_rd_a <= mem[i_raddr_a];
            r_rd_b <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

### hdl/lpgu_alu.sv
// Shared bit-serial unit: shift-add multiply and restoring divide, one bit per cycle.
// Depends on lpgu_pkg for the request and response structs.
`timescale 1ns / 1ps

module lpgu_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpgu_pkg::t_alu_req i_req,
    output lpgu_pkg::t_alu_rsp o_rsp
);

    logic                             r_busy;
    logic                             r_done;
    logic [lpgu_pkg::ALU_CNT_W-1:0]   r_cnt;
    lpgu_pkg::t_alu_op                r_op;
    logic [lpgu_pkg::ALU_A_W-1:0]     r_a;
    logic [lpgu_pkg::ALU_B_W-1:0]     r_div;
    logic [lpgu_pkg::ALU_P_W-1:0]     r_prod;
    logic [31:0]                      r_rem;
    logic [lpgu_pkg::ALU_A_W-1:0]     r_quo;

    logic [lpgu_pkg::ALU_A_W:0]       mul_sum;
    logic [lpgu_pkg::ALU_B_W-1:0]     div_trial;
    logic [lpgu_pkg::ALU_B_W-1:0]     div_diff;
    logic                             div_ge;
    logic                             start;

    assign start = i_req.start && !r_busy;

    always_comb begin
        mul_sum   = {1'b0, r_prod[lpgu_pkg::ALU_P_W-1:lpgu_pkg::ALU_B_W]}
                  + (r_prod[0] ? {1'b0, r_a} : '0);
        div_trial = {r_rem, r_quo[lpgu_pkg::ALU_A_W-1]};
        div_ge    = div_trial >= r_div;
        div_diff  = div_trial - r_div;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == lpgu_pkg::ALU_MUL)
                        ? lpgu_pkg::ALU_CNT_W'(lpgu_pkg::MUL_STEPS - 1)
                        : lpgu_pkg::ALU_CNT_W'(lpgu_pkg::DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_op   <= i_req.op;
            r_a    <= i_req.a;
            r_div  <= i_req.b;
            r_prod <= {{lpgu_pkg::ALU_A_W{1'b0}}, i_req.b};
            r_rem  <= '0;
            r_quo  <= i_req.a;
        end else if (r_busy) begin
            if (r_op == lpgu_pkg::ALU_MUL) begin
                r_prod <= {mul_sum, r_prod[lpgu_pkg::ALU_B_W-1:1]};
            end else begin
                r_rem <= div_ge ? div_diff[31:0] : div_trial[31:0];
                r_quo <= {r_quo[lpgu_pkg::ALU_A_W-2:0], div_ge};
            end
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = (r_op == lpgu_pkg::ALU_MUL) ? r_prod
                        : {{lpgu_pkg::ALU_B_W{1'b0}}, r_quo};

endmodule

### test/tb_layout_pair_gradient_update.sv
// Testbench for layout_pair_gradient_update: directed and random commands against
// an in-bench coordinate table and gradient predictor. Depends on lpgu_pkg and the RTL.
`timescale 1ns / 1ps

module tb_layout_pair_gradient_update;

    localparam logic [lpgu_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int POOL_N = 8;
    localparam int LONG_HOLD_CYCLES = 600;

    typedef struct {
        logic [lpgu_pkg::CMD_W-1:0]       cmd;
        logic [lpgu_pkg::VERTEX_W-1:0]    va;
        logic [lpgu_pkg::VERTEX_W-1:0]    vb;
        logic [lpgu_pkg::COORD_IDX_W-1:0] ci;
        logic [lpgu_pkg::VALUE_W-1:0]     wv;
        logic [lpgu_pkg::LR_W-1:0]        lr;
        logic                             att;
    } t_cmd_item;

    typedef struct {
        logic [lpgu_pkg::VALUE_W-1:0] rv;
        logic                         sat;
    } t_cmd_result;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic o_in_ready;
    logic [lpgu_pkg::CMD_W-1:0] i_command = '0;
    logic [lpgu_pkg::VERTEX_W-1:0] i_vertex_a = '0, i_vertex_b = '0;
    logic [lpgu_pkg::COORD_IDX_W-1:0] i_coordinate_index = '0;
    logic signed [lpgu_pkg::VALUE_W-1:0] i_write_value = '0;
    logic [lpgu_pkg::LR_W-1:0] i_learning_rate = '0;
    logic i_attract = 0;
    logic o_out_valid;
    logic i_out_ready = 0;
    logic signed [lpgu_pkg::VALUE_W-1:0] o_read_value;
    logic o_saturated;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [lpgu_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [lpgu_pkg::GAMMA_W-1:0] i_cfg_data = '0;

    layout_pair_gradient_update uut (.*);

    always #6 i_clk = ~i_clk;

    // coordinate table mirror; an entry exists only once written
    logic [lpgu_pkg::VALUE_W-1:0] coord_table[int];
    logic [lpgu_pkg::DIM_W-1:0]   dim_reg = lpgu_pkg::DIM_RESET;
    logic [lpgu_pkg::GAMMA_W-1:0] gamma_reg = lpgu_pkg::GAMMA_RESET;
    t_cmd_result                  expected_results[$];
    logic [lpgu_pkg::VERTEX_W-1:0] vtx_pool[POOL_N];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic long_hold = 0;
    int hold_cnt = 0;

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic logic [lpgu_pkg::VALUE_W-1:0] clip32(longint v, inout logic flag);
        if (v > 64'sd2147483647) begin
            flag = 1;
            v = 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1;
            v = -64'sd2147483648;
        end
        return v[31:0];
    endfunction

    function automatic logic pair_step(int a, int b, longint unsigned lr, logic att);
        longint unsigned dim, dsum, g, g1, mag, hi, lo, p, u;
        longint va_v, vb_v, diff, step;
        logic flag;
        flag = 0;
        dsum = 0;
        dim = dim_reg;
        if (dim < 1) dim = 1;
        if (dim > lpgu_pkg::MAX_DIMENSION_DEF) dim = lpgu_pkg::MAX_DIMENSION_DEF;
        if (lr > 65536) lr = 65536;
        for (int k = 0; k < dim; k++) begin
            diff = longint'($signed(coord_table[a*4+k])) - longint'($signed(coord_table[b*4+k]));
            mag = diff < 0 ? -diff : diff;
            dsum += (mag * mag) >> 16;
            if (dsum > 64'h7FFFFFFF) begin
                dsum = 64'h7FFFFFFF;
                flag = 1;
            end
        end
        if (att) begin
            g = (64'd1 << 49) / (64'd65536 + dsum);
        end else begin
            g1 = (longint'(gamma_reg) << 33) / (64'd65536 + dsum);
            g = (g1 << 16) / (64'd6554 + dsum);
        end
        for (int k = 0; k < dim; k++) begin
            va_v = longint'($signed(coord_table[a*4+k]));
            vb_v = longint'($signed(coord_table[b*4+k]));
            diff = va_v - vb_v;
            mag = diff < 0 ? -diff : diff;
            hi = mag >> 16;
            lo = mag & 64'hFFFF;
            p = (g * hi + ((g * lo) >> 16)) >> 16;
            if (p > 65536) p = 65536;
            u = (lr * p) >> 16;
            step = ((diff < 0) != att) ? -longint'(u) : longint'(u);
            coord_table[a*4+k] = clip32(va_v + step, flag);
            coord_table[b*4+k] = clip32(vb_v - step, flag);
        end
        return flag;
    endfunction

    function automatic t_cmd_result predict_command(t_cmd_item it);
        t_cmd_result r;
        r.rv = '0;
        r.sat = 0;
        case (it.cmd)
            lpgu_pkg::CMD_WRITE: coord_table[it.va*4+it.ci] = it.wv;
            lpgu_pkg::CMD_READ: r.rv = coord_table[it.va*4+it.ci];
            lpgu_pkg::CMD_UPDATE: r.sat = pair_step(it.va, it.vb, it.lr, it.att);
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_item(t_cmd_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1;
        i_command <= it.cmd;
        i_vertex_a <= it.va;
        i_vertex_b <= it.vb;
        i_coordinate_index <= it.ci;
        i_write_value <= it.wv;
        i_learning_rate <= it.lr;
        i_attract <= it.att;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.insert(expected_results.size(), predict_command(it));
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [lpgu_pkg::CFG_IDX_W-1:0] idx,
                             logic [lpgu_pkg::GAMMA_W-1:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == lpgu_pkg::CFG_DIMENSION) dim_reg = data[lpgu_pkg::DIM_W-1:0];
        else if (idx == lpgu_pkg::CFG_GAMMA) gamma_reg = data;
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic t_cmd_item mk(logic [lpgu_pkg::CMD_W-1:0] cmd, int va, int vb, int ci,
                                     logic [31:0] wv, int lr, logic att);
        t_cmd_item it;
        it.cmd = cmd;
        it.va = va[lpgu_pkg::VERTEX_W-1:0];
        it.vb = vb[lpgu_pkg::VERTEX_W-1:0];
        it.ci = ci[lpgu_pkg::COORD_IDX_W-1:0];
        it.wv = wv;
        it.lr = lr[lpgu_pkg::LR_W-1:0];
        it.att = att;
        return it;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'h7FFFFFFF - $urandom_range(3);
            default: return $signed($urandom_range(1 << 20)) - (1 << 19);
        endcase
    endfunction

    function automatic t_cmd_item rand_item();
        t_cmd_item it;
        int sel;
        sel = $urandom_range(99);
        it = mk(lpgu_pkg::CMD_UPDATE, vtx_pool[$urandom_range(POOL_N-1)],
                vtx_pool[$urandom_range(POOL_N-1)], $urandom_range(3), $urandom,
                $urandom_range(131071), $urandom_range(1));
        if (sel < 15) begin
            it.cmd = lpgu_pkg::CMD_READ;
        end else if (sel < 27) begin
            it.cmd = lpgu_pkg::CMD_WRITE;
            it.wv = rand_value();
        end else if (sel < 32) begin
            // unused command with arbitrary fields
            it = mk(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (sel < 35) begin
            // write to an arbitrary vertex, not necessarily one in the pool
            it = mk(lpgu_pkg::CMD_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom);
        end
        return it;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report("unexpected result", o_read_value, 0);
            end else begin
                t_cmd_result want;
                want = expected_results.pop_front();
                if (o_read_value !== want.rv) report("read_value", o_read_value, want.rv);
                if (o_saturated !== want.sat) report("saturated", o_saturated, want.sat);
            end
        end
    end

    // receiver: random stalls, or a long counted hold-off on request
    always @(posedge i_clk) begin
        if (long_hold && hold_cnt < LONG_HOLD_CYCLES) begin
            hold_cnt <= hold_cnt + 1;
            i_out_ready <= 0;
        end else begin
            if (!long_hold) hold_cnt <= 0;
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic test_pool_setup();
        vtx_pool[0] = 0;
        vtx_pool[1] = 16383;
        for (int i = 2; i < POOL_N; i++) vtx_pool[i] = 1 + i * 2047 + $urandom_range(1000);
        for (int i = 0; i < POOL_N; i++)
            for (int k = 0; k < 4; k++) send_item(mk(lpgu_pkg::CMD_WRITE, vtx_pool[i], 0, k,
                                                      rand_value(), 0, 0));
        drain();
    endtask

    task automatic test_directed();
        // opposite extremes on vertices 0 and 16383
        for (int k = 0; k < 4; k++) begin
            send_item(mk(lpgu_pkg::CMD_WRITE, 0, 0, k, 32'h7FFFFFFF, 0, 0));
            send_item(mk(lpgu_pkg::CMD_WRITE, 16383, 0, k, 32'h80000000, 0, 0));
        end
        send_item(mk(lpgu_pkg::CMD_UPDATE, 0, 16383, 0, 0, 65536, 0));
        send_item(mk(lpgu_pkg::CMD_UPDATE, 16383, 0, 0, 0, 131071, 1));
        send_item(mk(lpgu_pkg::CMD_UPDATE, 0, 16383, 0, 0, 0, 0));
        send_item(mk(lpgu_pkg::CMD_UPDATE, 0, 0, 0, 0, 65536, 1));
        send_item(mk(lpgu_pkg::CMD_READ, 0, 0, 0, 0, 0, 0));
        send_item(mk(lpgu_pkg::CMD_READ, 16383, 0, 3, 0, 0, 0));
        send_item(mk(CMD_UNUSED, 16383, 16383, 3, 32'hFFFFFFFF, 131071, 1));
        send_item(mk(lpgu_pkg::CMD_WRITE, vtx_pool[2], 0, 1, 32'h00010000, 0, 0));
        send_item(mk(lpgu_pkg::CMD_UPDATE, vtx_pool[2], vtx_pool[3], 0, 0, 65536, 0));
        send_item(mk(lpgu_pkg::CMD_UPDATE, vtx_pool[2], vtx_pool[3], 0, 0, 32768, 1));
        send_item(mk(lpgu_pkg::CMD_READ, vtx_pool[2], 0, 1, 0, 0, 0));
        drain();
    endtask

    task automatic test_config(int dim, int gamma);
        write_reg(lpgu_pkg::CFG_DIMENSION, dim[lpgu_pkg::GAMMA_W-1:0]);
        write_reg(lpgu_pkg::CFG_GAMMA, gamma[lpgu_pkg::GAMMA_W-1:0]);
        for (int i = 0; i < 6; i++) send_item(rand_item());
        drain();
    endtask

    task automatic test_random_phase(int n, int spct, int rpct);
        send_idle_pct = spct;
        recv_idle_pct = rpct;
        for (int i = 0; i < n; i++) send_item(rand_item());
        drain();
    endtask

    task automatic test_backpressure();
        long_hold <= 1;
        for (int i = 0; i < 8; i++) send_item(rand_item());
        drain();
        long_hold <= 0;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_pool_setup();
        test_directed();
        test_config(0, 0);
        test_config(7, 24'hFFFFFF);
        test_config(1, 1);
        write_reg(lpgu_pkg::CFG_DIMENSION, 24'd4);
        write_reg(lpgu_pkg::CFG_GAMMA, 24'h020000);
        test_random_phase(140, 35, 66);
        write_reg(lpgu_pkg::CFG_DIMENSION, 24'd3);
        write_reg(lpgu_pkg::CFG_GAMMA, lpgu_pkg::GAMMA_W'($urandom_range(24'hFFFFFF)));
        test_random_phase(140, 66, 35);
        test_backpressure();
        write_reg(lpgu_pkg::CFG_DIMENSION, 24'd2);
        write_reg(lpgu_pkg::CFG_GAMMA, 24'h010000);
        test_random_phase(140, 0, 0);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
